// File: hw/rtl/qte_pkg.sv
package qte_pkg;

    localparam int CW   = 45;
    localparam int AW   = 26;
    localparam int SW   = 32;
    localparam int SUMW = 34;
    localparam int RW   = 62;

    localparam logic signed [AW-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [AW-1:0] DEG90  = 26'sd5898240;

    typedef struct packed {
        logic                   flag;
        logic signed [SW-1:0]   s;
        logic signed [SUMW-1:0] axy;
        logic signed [SUMW-1:0] axx;
        logic signed [SUMW-1:0] azy;
        logic signed [SUMW-1:0] azx;
    } qte_side_t;

    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } qte_cord_t;

    function automatic logic [CW-1:0] cabs(input logic signed [CW-1:0] v);
        cabs = (v < 0) ? CW'(-v) : CW'(v);
    endfunction

    function automatic logic [21:0] atan_tab(input logic [4:0] i);
        case (i)
            5'd0:    atan_tab = 22'd2949120;
            5'd1:    atan_tab = 22'd1740967;
            5'd2:    atan_tab = 22'd919879;
            5'd3:    atan_tab = 22'd466945;
            5'd4:    atan_tab = 22'd234379;
            5'd5:    atan_tab = 22'd117304;
            5'd6:    atan_tab = 22'd58666;
            5'd7:    atan_tab = 22'd29335;
            5'd8:    atan_tab = 22'd14668;
            5'd9:    atan_tab = 22'd7334;
            5'd10:   atan_tab = 22'd3667;
            5'd11:   atan_tab = 22'd1833;
            5'd12:   atan_tab = 22'd917;
            5'd13:   atan_tab = 22'd458;
            5'd14:   atan_tab = 22'd229;
            5'd15:   atan_tab = 22'd115;
            5'd16:   atan_tab = 22'd57;
            5'd17:   atan_tab = 22'd29;
            5'd18:   atan_tab = 22'd14;
            5'd19:   atan_tab = 22'd7;
            5'd20:   atan_tab = 22'd4;
            5'd21:   atan_tab = 22'd2;
            5'd22:   atan_tab = 22'd1;
            default: atan_tab = 22'd0;
        endcase
    endfunction

endpackage

// File: hw/rtl/qte_isqrt.sv
module qte_isqrt
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  qte_side_t            side_in,
    input  logic [RW-2:0]        rad_in,
    output logic                 vld_out,
    output qte_side_t            side_out,
    output logic [SW-1:0]        root_out
);

    localparam int NST = 31;

    logic            vld_reg  [0:NST];
    qte_side_t       side_reg [0:NST];
    logic [RW-1:0]   v_reg    [0:NST];
    logic [RW-1:0]   r_reg    [0:NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        v_reg[0]    <= RW'(rad_in);
        r_reg[0]    <= '0;
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        localparam logic [RW-1:0] BITV = RW'(1) << (60 - 2 * k);
        logic [RW-1:0] v_next;
        logic [RW-1:0] r_next;
        logic [RW-1:0] t;

        always_comb
        begin
            t = r_reg[k] + BITV;
            if (v_reg[k] >= t)
            begin
                v_next = v_reg[k] - t;
                r_next = (r_reg[k] >> 1) + BITV;
            end
            else
            begin
                v_next = v_reg[k];
                r_next = r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_reg[k];
            v_reg[k+1]    <= v_next;
            r_reg[k+1]    <= r_next;
        end
    end

    assign vld_out  = vld_reg[NST];
    assign side_out = side_reg[NST];
    assign root_out = r_reg[NST][SW-1:0];

endmodule

// File: hw/rtl/qte_atan2.sv
module qte_atan2
    import qte_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] x_in,
    output logic                 vld_out,
    output logic signed [AW-1:0] ang_out
);

    localparam int NSTEP = (STEPS < 32) ? STEPS : 32;
    localparam int LAST  = 8 + NSTEP;

    logic      vld_reg [0:LAST];
    qte_cord_t d_reg   [0:LAST];
    logic                 vo_reg;
    logic signed [AW-1:0] ang_reg;
    logic signed [AW-1:0] ang_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vo_reg     <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= vld_in;
            vo_reg     <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0].zero <= (x_in == '0) && (y_in == '0);
        d_reg[0].x    <= x_in;
        d_reg[0].y    <= y_in;
        d_reg[0].ang  <= '0;
        ang_reg       <= ang_next;
    end

    for (genvar k = 1; k <= LAST; k++)
    begin : g_st
        qte_cord_t nxt;

        if (k <= 6)
        begin : g_norm
            localparam int SH = 32 >> (k - 1);
            localparam logic [CW-1:0] LIM = CW'(1) << (40 - SH);
            always_comb
            begin
                nxt = d_reg[k-1];
                if (cabs(d_reg[k-1].x) < LIM && cabs(d_reg[k-1].y) < LIM)
                begin
                    nxt.x = d_reg[k-1].x <<< SH;
                    nxt.y = d_reg[k-1].y <<< SH;
                end
            end
        end
        else if (k == 7)
        begin : g_fin
            localparam logic [CW-1:0] LIM = CW'(1) << 40;
            always_comb
            begin
                nxt = d_reg[k-1];
                if (cabs(d_reg[k-1].x) < LIM && cabs(d_reg[k-1].y) < LIM)
                begin
                    nxt.x = d_reg[k-1].x <<< 1;
                    nxt.y = d_reg[k-1].y <<< 1;
                end
            end
        end
        else if (k == 8)
        begin : g_sign
            always_comb
            begin
                nxt = d_reg[k-1];
                if (d_reg[k-1].x < 0)
                begin
                    nxt.ang = (d_reg[k-1].y >= 0) ? DEG180 : -DEG180;
                    nxt.x   = -d_reg[k-1].x;
                    nxt.y   = -d_reg[k-1].y;
                end
            end
        end
        else
        begin : g_rot
            localparam int I = k - 9;
            localparam logic signed [AW-1:0] TA = AW'(atan_tab(5'(I)));
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            always_comb
            begin
                nxt = d_reg[k-1];
                dx  = d_reg[k-1].y >>> I;
                dy  = d_reg[k-1].x >>> I;
                if (d_reg[k-1].y >= 0)
                begin
                    nxt.x   = d_reg[k-1].x + dx;
                    nxt.y   = d_reg[k-1].y - dy;
                    nxt.ang = d_reg[k-1].ang + TA;
                end
                else
                begin
                    nxt.x   = d_reg[k-1].x - dx;
                    nxt.y   = d_reg[k-1].y + dy;
                    nxt.ang = d_reg[k-1].ang - TA;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[k] <= nxt;
        end
    end

    always_comb
    begin
        if (d_reg[LAST].zero)
        begin
            ang_next = '0;
        end
        else if (d_reg[LAST].ang > DEG180)
        begin
            ang_next = DEG180;
        end
        else if (d_reg[LAST].ang < -DEG180)
        begin
            ang_next = -DEG180;
        end
        else
        begin
            ang_next = d_reg[LAST].ang;
        end
    end

    assign vld_out = vo_reg;
    assign ang_out = ang_reg;

endmodule

// File: hw/rtl/quaternion_to_euler_angles.sv
// Channel   Direction  Signals                                      Transaction
// command   in         start, busy, quat_w, quat_x, quat_y, quat_z  start high, busy low
// result    out        done, angle_about_x, angle_about_y,          done high, one cycle
//                      angle_about_z, asin_clamped
//
// One quaternion is accepted every cycle; busy is always low.
// Each result passes through the product stages, the square root, the CORDIC pipeline
// and the rounding stages.
// Reset clears only the valid bits, so any transaction in flight is dropped.
// The receiver cannot stall, so the pipeline advances every cycle.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int QUAT_WIDTH      = 16,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS    = 16,
    localparam int XW = $clog2((180 << ANGLE_FRAC_BITS) + 1) + 1,
    localparam int YW = $clog2((90 << ANGLE_FRAC_BITS) + 1) + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    output logic                         done,
    output logic signed [XW-1:0]         angle_about_x,
    output logic signed [YW-1:0]         angle_about_y,
    output logic signed [XW-1:0]         angle_about_z,
    output logic                         asin_clamped
);

    localparam int NSTEP    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int ATAN_LAT = NSTEP + 10;
    localparam int SH       = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [AW:0] HALF = (AW + 1)'((1 << SH) >> 1);
    localparam logic signed [AW:0] LIMX = (AW + 1)'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [AW:0] LIMY = (AW + 1)'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [SUMW-1:0] UNIT = SUMW'(64'sd1 << 30);
    localparam logic [RW-2:0] ONE_SQ = (RW - 1)'(64'd1 << 60);

    logic signed [15:0] lw;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;

    if (QUAT_WIDTH > 16)
    begin : g_narrow
        assign lw = 16'(quat_w >>> (QUAT_WIDTH - 16));
        assign lx = 16'(quat_x >>> (QUAT_WIDTH - 16));
        assign ly = 16'(quat_y >>> (QUAT_WIDTH - 16));
        assign lz = 16'(quat_z >>> (QUAT_WIDTH - 16));
    end
    else
    begin : g_widen
        assign lw = 16'(quat_w) <<< (16 - QUAT_WIDTH);
        assign lx = 16'(quat_x) <<< (16 - QUAT_WIDTH);
        assign ly = 16'(quat_y) <<< (16 - QUAT_WIDTH);
        assign lz = 16'(quat_z) <<< (16 - QUAT_WIDTH);
    end

    assign busy = 1'b0;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] yz_reg, xw_reg, xy_reg, zw_reg, yw_reg, xz_reg;
    logic signed [SUMW-1:0] axy_reg, axx_reg, azy_reg, azx_reg, sr_reg;
    qte_side_t side3_reg, side4_reg, side5_reg;
    qte_side_t side3_next;
    logic [RW-2:0] sq_reg;
    logic [SW-2:0] smag;
    logic [RW-2:0] rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        side3_next.axy  = axy_reg;
        side3_next.axx  = axx_reg;
        side3_next.azy  = azy_reg;
        side3_next.azx  = azx_reg;
        side3_next.flag = (sr_reg > UNIT) || (sr_reg < -UNIT);
        if (sr_reg > UNIT)
        begin
            side3_next.s = SW'(UNIT);
        end
        else if (sr_reg < -UNIT)
        begin
            side3_next.s = SW'(-UNIT);
        end
        else
        begin
            side3_next.s = SW'(sr_reg);
        end
    end

    assign smag = (side3_reg.s < 0) ? (SW - 1)'(-side3_reg.s) : (SW - 1)'(side3_reg.s);

    always_ff @(posedge clk)
    begin
        w_reg     <= lw;
        x_reg     <= lx;
        y_reg     <= ly;
        z_reg     <= lz;
        ww_reg    <= w_reg * w_reg;
        xx_reg    <= x_reg * x_reg;
        yy_reg    <= y_reg * y_reg;
        zz_reg    <= z_reg * z_reg;
        yz_reg    <= y_reg * z_reg;
        xw_reg    <= x_reg * w_reg;
        xy_reg    <= x_reg * y_reg;
        zw_reg    <= z_reg * w_reg;
        yw_reg    <= y_reg * w_reg;
        xz_reg    <= x_reg * z_reg;
        axy_reg   <= (SUMW'(yz_reg) + SUMW'(xw_reg)) <<< 1;
        axx_reg   <= SUMW'(ww_reg) - SUMW'(xx_reg) - SUMW'(yy_reg) + SUMW'(zz_reg);
        azy_reg   <= (SUMW'(xy_reg) + SUMW'(zw_reg)) <<< 1;
        azx_reg   <= SUMW'(ww_reg) + SUMW'(xx_reg) - SUMW'(yy_reg) - SUMW'(zz_reg);
        sr_reg    <= (SUMW'(yw_reg) - SUMW'(xz_reg)) <<< 1;
        side3_reg <= side3_next;
        side4_reg <= side3_reg;
        sq_reg    <= (RW - 1)'(smag) * (RW - 1)'(smag);
        side5_reg <= side4_reg;
        rad_reg   <= ONE_SQ - sq_reg;
    end

    logic          sq_vld;
    qte_side_t     sq_side;
    logic [SW-1:0] root;

    qte_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (v5_reg),
        .side_in  (side5_reg),
        .rad_in   (rad_reg),
        .vld_out  (sq_vld),
        .side_out (sq_side),
        .root_out (root)
    );

    logic ax_vld, ay_vld, az_vld;
    logic signed [AW-1:0] ax_ang, ay_ang, az_ang;

    qte_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_x
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (sq_vld),
        .y_in    (CW'(sq_side.axy)),
        .x_in    (CW'(sq_side.axx)),
        .vld_out (ax_vld),
        .ang_out (ax_ang)
    );

    qte_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_y
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (sq_vld),
        .y_in    (CW'(sq_side.s)),
        .x_in    (CW'({1'b0, root})),
        .vld_out (ay_vld),
        .ang_out (ay_ang)
    );

    qte_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_z
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (sq_vld),
        .y_in    (CW'(sq_side.azy)),
        .x_in    (CW'(sq_side.azx)),
        .vld_out (az_vld),
        .ang_out (az_ang)
    );

    logic flg_reg [0:ATAN_LAT-1];

    always_ff @(posedge clk)
    begin
        flg_reg[0] <= sq_side.flag;
    end

    for (genvar k = 1; k < ATAN_LAT; k++)
    begin : g_flg
        always_ff @(posedge clk)
        begin
            flg_reg[k] <= flg_reg[k-1];
        end
    end

    logic f1_reg, f2_reg, f3_reg;
    logic c1_reg, c2_reg;
    logic signed [AW-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [AW-1:0] ay_next;
    logic signed [AW:0] x2_reg, y2_reg, z2_reg;
    logic signed [AW:0] x3_next, y3_next, z3_next;

    always_comb
    begin
        if (ay_ang > DEG90)
        begin
            ay_next = DEG90;
        end
        else if (ay_ang < -DEG90)
        begin
            ay_next = -DEG90;
        end
        else
        begin
            ay_next = ay_ang;
        end
    end

    always_comb
    begin
        x3_next = (x2_reg > LIMX) ? LIMX : ((x2_reg < -LIMX) ? -LIMX : x2_reg);
        y3_next = (y2_reg > LIMY) ? LIMY : ((y2_reg < -LIMY) ? -LIMY : y2_reg);
        z3_next = (z2_reg > LIMX) ? LIMX : ((z2_reg < -LIMX) ? -LIMX : z2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
            f3_reg <= 1'b0;
        end
        else
        begin
            f1_reg <= ax_vld;
            f2_reg <= f1_reg;
            f3_reg <= f2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg        <= ax_ang;
        y1_reg        <= ay_next;
        z1_reg        <= az_ang;
        c1_reg        <= flg_reg[ATAN_LAT-1];
        x2_reg        <= ((AW + 1)'(x1_reg) + HALF) >>> SH;
        y2_reg        <= ((AW + 1)'(y1_reg) + HALF) >>> SH;
        z2_reg        <= ((AW + 1)'(z1_reg) + HALF) >>> SH;
        c2_reg        <= c1_reg;
        angle_about_x <= XW'(x3_next);
        angle_about_y <= YW'(y3_next);
        angle_about_z <= XW'(z3_next);
        asin_clamped  <= c2_reg;
    end

    assign done = f3_reg;

`ifndef ASSERT_OFF
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (ax_vld == ay_vld) && (ay_vld == az_vld))
        else $error("atan2 lanes lost alignment");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((AW + 1)'(angle_about_x) <= LIMX) && ((AW + 1)'(angle_about_x) >= -LIMX))
        else $error("angle about x out of range");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((AW + 1)'(angle_about_y) <= LIMY) && ((AW + 1)'(angle_about_y) >= -LIMY))
        else $error("angle about y out of range");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((AW + 1)'(angle_about_z) <= LIMX) && ((AW + 1)'(angle_about_z) >= -LIMX))
        else $error("angle about z out of range");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

class euler_scoreboard;
    logic [15:0] exp_ax[$];
    logic [14:0] exp_ay[$];
    logic [15:0] exp_az[$];
    logic        exp_fl[$];
    int          errors;

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    static function longint atan2_deg16(longint y, longint x);
        longint ang;
        longint dx;
        longint dy;
        longint steps[16];
        ang = 0;
        steps = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                  14668, 7334, 3667, 1833, 917, 458, 229, 115};
        if (x == 0 && y == 0)
            return 0;
        while (abs64(x) < (64'sd1 <<< 40) && abs64(y) < (64'sd1 <<< 40))
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + steps[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - steps[i];
            end
        end
        if (ang > 180 * 65536) ang = 180 * 65536;
        if (ang < -180 * 65536) ang = -180 * 65536;
        return ang;
    endfunction

    static function longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    static function longint round_angle(longint a, longint lim);
        longint r;
        r = (a + 256) >>> 9;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function void note_input(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz);
        longint w;
        longint x;
        longint y;
        longint z;
        longint s;
        longint c;
        longint ax;
        longint ay;
        longint az;
        longint rx;
        longint ry;
        longint rz;
        logic fl;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        fl = 1'b0;
        ax = atan2_deg16(2 * (y * z + x * w), w * w - x * x - y * y + z * z);
        az = atan2_deg16(2 * (x * y + z * w), w * w + x * x - y * y - z * z);
        s = 2 * (y * w - x * z);
        if (s > (64'sd1 <<< 30))
        begin
            s = 64'sd1 <<< 30;
            fl = 1'b1;
        end
        if (s < -(64'sd1 <<< 30))
        begin
            s = -(64'sd1 <<< 30);
            fl = 1'b1;
        end
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        ay = atan2_deg16(s, c);
        if (ay > 90 * 65536) ay = 90 * 65536;
        if (ay < -90 * 65536) ay = -90 * 65536;
        rx = round_angle(ax, 180 * 128);
        ry = round_angle(ay, 90 * 128);
        rz = round_angle(az, 180 * 128);
        exp_ax.push_back(rx[15:0]);
        exp_ay.push_back(ry[14:0]);
        exp_az.push_back(rz[15:0]);
        exp_fl.push_back(fl);
    endfunction

    function void check_result(logic [15:0] ax, logic [14:0] ay, logic [15:0] az,
                               logic fl);
        logic [15:0] ex;
        logic [14:0] ey;
        logic [15:0] ez;
        logic        ef;
        if (exp_ax.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result: %0d %0d %0d %0d",
                         $signed(ax), $signed(ay), $signed(az), fl);
            return;
        end
        ex = exp_ax.pop_front();
        ey = exp_ay.pop_front();
        ez = exp_az.pop_front();
        ef = exp_fl.pop_front();
        if (ax !== ex || ay !== ey || az !== ez || fl !== ef)
        begin
            errors++;
            if (errors <= 10)
                $display("Mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                         $signed(ex), $signed(ey), $signed(ez), ef,
                         $signed(ax), $signed(ay), $signed(az), fl);
        end
    endfunction

    function int pending();
        return exp_ax.size();
    endfunction
endclass

module testbench;
    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               done;
    logic signed [15:0] angle_about_x;
    logic signed [14:0] angle_about_y;
    logic signed [15:0] angle_about_z;
    logic               asin_clamped;

    euler_scoreboard sb;

    quaternion_to_euler_angles uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .done(done),
        .angle_about_x(angle_about_x),
        .angle_about_y(angle_about_y),
        .angle_about_z(angle_about_z),
        .asin_clamped(asin_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(angle_about_x, angle_about_y, angle_about_z, asin_clamped);
    end

    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 1) == 0)
            gap = 0;
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(w, x, y, z);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] ext[6];
        int wait_cycles;
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
        sb = new();
        rst_n  = 1'b0;
        start  = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000);
        send_quat(16'h5A82, 16'h0000, 16'hA57E, 16'h0000);
        send_quat(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
        send_quat(16'h8000, 16'h0000, 16'h7FFF, 16'h0000);
        send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
        for (int i = 0; i < 8; i++)
            send_quat(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                      ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)]);

        for (int i = 0; i < 900; i++)
        begin
            if ((i / 100) % 2 == 1)
            begin
                start  <= 1'b1;
                quat_w <= pick_value();
                quat_x <= pick_value();
                quat_y <= pick_value();
                quat_z <= pick_value();
                @(posedge clk);
                while (busy)
                    @(posedge clk);
                sb.note_input(quat_w, quat_x, quat_y, quat_z);
                @(negedge clk);
            end
            else
                send_quat(pick_value(), pick_value(), pick_value(), pick_value());
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
